// File: src/dsu_pkg.sv
// Shared types and constants for the disjoint-set union-find engine.
// No dependencies; every other file but dsu_ram imports this package.
package dsu_pkg;

  localparam int NODE_W = 8;
  localparam int ACT_W  = 2;
  localparam int CFG_W  = 9;
  localparam int RANK_W = 4;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CFG_W-1:0]  count_t;

  localparam action_t ACT_FIND  = 2'd0;
  localparam action_t ACT_UNION = 2'd1;
  localparam action_t ACT_CONN  = 2'd2;

  localparam rank_t  RANK_MAX      = 4'd15;
  localparam count_t NUM_NODES_RST = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_NODES = 1'b0;

endpackage

// File: src/dsu_if.sv
// Valid/ready channel interfaces for the union-find engine request and result words.
// Depends on dsu_pkg.
interface dsu_in_if;
  import dsu_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  node_t   node_a;
  node_t   node_b;
  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface dsu_out_if;
  import dsu_pkg::*;
  logic  valid;
  logic  ready;
  node_t root;
  logic  same_set;
  logic  merged;
  logic  bad_index;
  modport source (output valid, root, same_set, merged, bad_index, input ready);
  modport sink   (input valid, root, same_set, merged, bad_index, output ready);
endinterface

// File: src/dsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/dsu_find.sv
// Find unit: walks a parent chain to its root, then walks it again pointing each node at the root.
// Drives the parent RAM ports; one shared equality compare serves both walks. Depends on dsu_pkg.
module dsu_find #(
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] node,
  input  logic [NW-1:0] rdata,
  output logic [NW-1:0] raddr,
  output logic          we,
  output logic [NW-1:0] waddr,
  output logic [NW-1:0] wdata,
  output logic          done,
  output logic [NW-1:0] root
);
  import dsu_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_UP   = 2'd1;
  localparam logic [1:0] F_DOWN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] r_r, r_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic          hit;

  // shared compare: parent vs current node going up, parent vs root going down
  assign hit = (rdata == r_r);

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    cur_nxt   = cur_r;
    raddr     = cur_r;
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = r_r;
    done      = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          r_nxt     = node;
          cur_nxt   = node;
          raddr     = node;
          state_nxt = F_UP;
        end
      end
      F_UP: begin
        if (hit) begin
          raddr     = cur_r;
          state_nxt = F_DOWN;
        end else begin
          r_nxt = rdata;
          raddr = rdata;
        end
      end
      F_DOWN: begin
        we = 1'b1;
        if (hit) begin
          done      = 1'b1;
          state_nxt = F_IDLE;
        end else begin
          cur_nxt = rdata;
          raddr   = rdata;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    cur_r <= cur_nxt;
  end

  assign root = r_r;

endmodule

// File: src/disjoint_set_union_find.sv
// Top level of the disjoint-set union-find engine: sequencer, rank/union logic, APB register.
// Depends on dsu_pkg, dsu_if, dsu_ram and dsu_find.
//
// One word at a time: find, union by rank, or connected test, each find with path compression.
// A find walks the parent chain up to the root and then down again, bound by the parent
// RAM's one read per cycle. For a union or connected test the root of node_b is sought
// after the path of node_a is compressed; a union that merges then reads both ranks
// before it links the roots. Each item also waits for the result register to drain.
// After reset a clearing pass over all MAX_NODES entries rebuilds the tables; in_ch.ready
// stays low meanwhile, while num_nodes writes are taken. Bad indices and action 3 go
// straight to the result phase; the result word is held in the result registers and
// then in the output register.
module disjoint_set_union_find #(
  parameter int MAX_NODES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dsu_in_if.sink                      in_ch,
  dsu_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dsu_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [dsu_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [dsu_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import dsu_pkg::*;

  localparam int          NW      = $clog2(MAX_NODES);
  localparam logic [12:0] LIM_MAX = 13'(MAX_NODES);
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_FA   = 3'd2;
  localparam logic [2:0] ST_FBGO = 3'd3;
  localparam logic [2:0] ST_FB   = 3'd4;
  localparam logic [2:0] ST_RKA  = 3'd5;
  localparam logic [2:0] ST_RKB  = 3'd6;
  localparam logic [2:0] ST_RES  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] clr_idx_r, clr_idx_nxt;
  count_t        num_nodes_r;
  action_t       act_r, act_nxt;
  node_t         b_r, b_nxt;
  logic [NW-1:0] ra_r, ra_nxt;
  logic [NW-1:0] rb_r, rb_nxt;
  rank_t         rka_r, rka_nxt;
  node_t         res_root_r, res_root_nxt;
  logic          res_same_r, res_same_nxt;
  logic          res_merged_r, res_merged_nxt;
  logic          res_bad_r, res_bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  node_t         out_root_r;
  logic          out_same_r, out_merged_r, out_bad_r;
  logic          out_load;

  logic          accept, a_ok, b_ok, same;
  logic          f_start, f_we, f_done;
  logic [NW-1:0] f_node, f_raddr, f_waddr, f_wdata, f_root;
  logic          p_we, mg_we;
  logic [NW-1:0] p_waddr, p_wdata, p_rdata, mg_waddr, mg_wdata;
  logic          rk_we;
  logic [NW-1:0] rk_waddr, rk_raddr;
  rank_t         rk_wdata, rk_rdata;

  // range checks against min(num_nodes, MAX_NODES)
  assign a_ok = ({1'b0, in_ch.node_a} < num_nodes_r) && (13'(in_ch.node_a) < LIM_MAX);
  assign b_ok = ({1'b0, in_ch.node_b} < num_nodes_r) && (13'(in_ch.node_b) < LIM_MAX);
  assign same = (ra_r == f_root);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_RES) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    act_nxt        = act_r;
    b_nxt          = b_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    rka_nxt        = rka_r;
    res_root_nxt   = res_root_r;
    res_same_nxt   = res_same_r;
    res_merged_nxt = res_merged_r;
    res_bad_nxt    = res_bad_r;
    f_start        = 1'b0;
    f_node         = NW'(in_ch.node_a);
    mg_we          = 1'b0;
    mg_waddr       = rb_r;
    mg_wdata       = ra_r;
    rk_we          = 1'b0;
    rk_waddr       = ra_r;
    rk_wdata       = rka_r + 4'd1;
    case (state_r)
      ST_CLR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          act_nxt        = in_ch.action;
          b_nxt          = in_ch.node_b;
          res_root_nxt   = '0;
          res_same_nxt   = 1'b0;
          res_merged_nxt = 1'b0;
          res_bad_nxt    = 1'b0;
          state_nxt      = ST_RES;
          case (in_ch.action)
            ACT_FIND: begin
              if (a_ok) begin
                f_start   = 1'b1;
                state_nxt = ST_FA;
              end else begin
                res_bad_nxt = 1'b1;
              end
            end
            ACT_UNION, ACT_CONN: begin
              if (a_ok && b_ok) begin
                f_start   = 1'b1;
                state_nxt = ST_FA;
              end else begin
                res_bad_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = ST_RES;
            end
          endcase
        end
      end
      ST_FA: begin
        if (f_done) begin
          ra_nxt = f_root;
          if (act_r == ACT_FIND) begin
            res_root_nxt = NODE_W'(f_root);
            state_nxt    = ST_RES;
          end else begin
            state_nxt = ST_FBGO;
          end
        end
      end
      ST_FBGO: begin
        f_start   = 1'b1;
        f_node    = NW'(b_r);
        state_nxt = ST_FB;
      end
      ST_FB: begin
        if (f_done) begin
          rb_nxt       = f_root;
          res_root_nxt = NODE_W'(ra_r);
          res_same_nxt = same;
          if (act_r == ACT_UNION && !same) begin
            state_nxt = ST_RKA;
          end else begin
            state_nxt = ST_RES;
          end
        end
      end
      ST_RKA: begin
        rka_nxt   = rk_rdata;
        state_nxt = ST_RKB;
      end
      ST_RKB: begin
        res_merged_nxt = 1'b1;
        mg_we          = 1'b1;
        if (rka_r < rk_rdata) begin
          mg_waddr     = ra_r;
          mg_wdata     = rb_r;
          res_root_nxt = NODE_W'(rb_r);
        end else if (rka_r == rk_rdata && rka_r != RANK_MAX) begin
          rk_we = 1'b1;
        end
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // parent RAM write port: find unit, clearing pass, or union link
  always_comb begin
    p_we    = f_we || mg_we || (state_r == ST_CLR);
    p_waddr = mg_waddr;
    p_wdata = mg_wdata;
    if (f_we) begin
      p_waddr = f_waddr;
      p_wdata = f_wdata;
    end else if (state_r == ST_CLR) begin
      p_waddr = clr_idx_r;
      p_wdata = clr_idx_r;
    end
  end

  assign rk_raddr = (state_r == ST_FB) ? ra_r : rb_r;

  dsu_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NW)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (f_raddr),
    .rdata (p_rdata)
  );

  dsu_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES), .AW(NW)) u_rank (
    .clk   (clk),
    .we    (rk_we || (state_r == ST_CLR)),
    .waddr ((state_r == ST_CLR) ? clr_idx_r : rk_waddr),
    .wdata ((state_r == ST_CLR) ? '0 : rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  dsu_find #(.NW(NW)) u_find (
    .clk   (clk),
    .rst_n (rst_n),
    .start (f_start),
    .node  (f_node),
    .rdata (p_rdata),
    .raddr (f_raddr),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .done  (f_done),
    .root  (f_root)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      num_nodes_r <= NUM_NODES_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_NUM_NODES) begin
        num_nodes_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    b_r          <= b_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    rka_r        <= rka_nxt;
    res_root_r   <= res_root_nxt;
    res_same_r   <= res_same_nxt;
    res_merged_r <= res_merged_nxt;
    res_bad_r    <= res_bad_nxt;
    if (out_load) begin
      out_root_r   <= res_root_r;
      out_same_r   <= res_same_r;
      out_merged_r <= res_merged_r;
      out_bad_r    <= res_bad_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.root      = out_root_r;
  assign out_ch.same_set  = out_same_r;
  assign out_ch.merged    = out_merged_r;
  assign out_ch.bad_index = out_bad_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_NODES) ? APB_DW'(num_nodes_r) : '0;

  a_done_in_find: assert property (@(posedge clk) disable iff (!rst_n)
    f_done |-> (state_r == ST_FA || state_r == ST_FB))
    else $error("find unit finished outside a find phase");

  a_we_in_find: assert property (@(posedge clk) disable iff (!rst_n)
    f_we |-> (state_r == ST_FA || state_r == ST_FB))
    else $error("find unit wrote the parent table outside a find phase");

  a_valid_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RES))
    else $error("result word appeared without a result phase");

  a_merge_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_merged_r && (out_same_r || out_bad_r)))
    else $error("merged word also flagged same set or bad index");

endmodule

// File: tb/disjoint_set_union_find_tb.sv
// Self-checking testbench for disjoint_set_union_find: find, union and connected words are
// checked against a local union-find table with path compression and union by rank.
// Depends on dsu_pkg, dsu_if and the RTL top level.
module disjoint_set_union_find_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsu_pkg::*;

  localparam int      MAX_NODES   = 256;
  localparam action_t ACT_NONE    = 2'd3;
  localparam int      IDLE_LIMIT  = 4000;
  localparam int      HOLD_CYCLES = 600;
  localparam int      TAIL_CYCLES = 60;
  localparam int      PHASE_WORDS = 155;
  localparam logic [APB_AW-1:0] NUM_NODES_ADDR = {REG_NUM_NODES, 2'b00};

  typedef struct packed {
    action_t act;
    node_t   a;
    node_t   b;
  } dsu_word_t;

  typedef struct packed {
    node_t root;
    logic  same_set;
    logic  merged;
    logic  bad_index;
  } dsu_result_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  dsu_in_if  in_ch ();
  dsu_out_if out_ch ();

  disjoint_set_union_find #(.MAX_NODES(MAX_NODES)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the forest and the node count
  node_t       parent_tbl [MAX_NODES];
  rank_t       rank_tbl   [MAX_NODES];
  count_t      node_count;

  dsu_word_t   word_backlog [$];
  dsu_result_t answers_due  [$];
  int          faults;
  int          words_queued;
  int          stim_lim;
  int          next_fresh;
  int          idle_cycles;

  function automatic node_t seek_root(input node_t x);
    node_t r;
    node_t cur;
    node_t nxt;
    int    steps;
    r = x;
    steps = 0;
    while (parent_tbl[r] != r && steps < MAX_NODES) begin
      r = parent_tbl[r];
      steps++;
    end
    cur = x;
    steps = 0;
    while (cur != r && steps < MAX_NODES) begin
      nxt = parent_tbl[cur];
      parent_tbl[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic dsu_result_t resolve_word(input dsu_word_t w);
    dsu_result_t res;
    int          lim;
    node_t       ra;
    node_t       rb;
    res = '0;
    lim = (node_count > MAX_NODES) ? MAX_NODES : node_count;
    case (w.act)
      ACT_FIND: begin
        if (w.a >= lim) res.bad_index = 1'b1;
        else res.root = seek_root(w.a);
      end
      ACT_UNION, ACT_CONN: begin
        if (w.a >= lim || w.b >= lim) begin
          res.bad_index = 1'b1;
        end else begin
          ra = seek_root(w.a);
          rb = seek_root(w.b);
          res.same_set = (ra == rb);
          res.root = ra;
          if (w.act == ACT_UNION && ra != rb) begin
            res.merged = 1'b1;
            if (rank_tbl[ra] < rank_tbl[rb]) begin
              parent_tbl[ra] = rb;
              res.root = rb;
            end else if (rank_tbl[ra] > rank_tbl[rb]) begin
              parent_tbl[rb] = ra;
            end else begin
              parent_tbl[rb] = ra;
              if (rank_tbl[ra] < RANK_MAX) rank_tbl[ra] = rank_tbl[ra] + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender: bursts of random length, random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        void'(word_backlog.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (word_backlog.size() > 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.action <= word_backlog[0].act;
        in_ch.node_a <= word_backlog[0].a;
        in_ch.node_b <= word_backlog[0].b;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode now and then; two long hold-offs, each started
  // while plenty of words are still pending
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       hold_left;
  int       holds_done;
  int       words_taken;
  logic     rx_ready;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      = RX_STEADY;
      rx_mode_left = 0;
      hold_left    = 0;
      holds_done   = 0;
      words_taken  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_taken++;
      end
      if (holds_done < 2 && words_taken >= ((holds_done == 0) ? 420 : 900) &&
          word_backlog.size() >= 32) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_t'($urandom_range(0, 2));
          rx_mode_left = $urandom_range(32, 256);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_STEADY: rx_ready = 1'b1;
          RX_COIN:   rx_ready = $urandom_range(0, 1);
          default:   rx_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
      out_ch.ready <= rx_ready;
    end
  end

  // monitor: check results, predict accepted words, track register traffic
  dsu_result_t got;
  dsu_result_t want;
  dsu_word_t   seen;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.root      = out_ch.root;
        got.same_set  = out_ch.same_set;
        got.merged    = out_ch.merged;
        got.bad_index = out_ch.bad_index;
        if (answers_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result word: root=%0d same_set=%b merged=%b bad_index=%b",
                     got.root, got.same_set, got.merged, got.bad_index);
        end else begin
          want = answers_due.pop_front();
          if (got.root !== want.root || got.same_set !== want.same_set ||
              got.merged !== want.merged || got.bad_index !== want.bad_index) begin
            faults++;
            if (faults <= 10)
              $display("result mismatch: exp root=%0d same_set=%b merged=%b bad_index=%b",
                       want.root, want.same_set, want.merged, want.bad_index,
                       " / got root=%0d same_set=%b merged=%b bad_index=%b",
                       got.root, got.same_set, got.merged, got.bad_index);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.act = in_ch.action;
        seen.a   = in_ch.node_a;
        seen.b   = in_ch.node_b;
        answers_due.push_back(resolve_word(seen));
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_NUM_NODES) node_count = cfg_pwdata[CFG_W-1:0];
        end else if (cfg_prdata[CFG_W-1:0] !== node_count) begin
          faults++;
          if (faults <= 10)
            $display("num_nodes readback mismatch: exp %0d got %0d",
                     node_count, cfg_prdata[CFG_W-1:0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_word(input action_t act, input int a, input int b);
    dsu_word_t w;
    w.act = act;
    w.a   = a[NODE_W-1:0];
    w.b   = b[NODE_W-1:0];
    word_backlog.push_back(w);
    words_queued++;
  endtask

  // wait until every word is out and answered, then let the block go quiet
  task automatic settle();
    do @(negedge clk); while (word_backlog.size() != 0 || answers_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // write num_nodes, then read it back
  task automatic set_node_count(input logic [APB_DW-1:0] value);
    settle();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= NUM_NODES_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    stim_lim = (value[CFG_W-1:0] > MAX_NODES) ? MAX_NODES : value[CFG_W-1:0];
  endtask

  // fresh block of 2**k nodes joined pairwise in doubling rounds through
  // randomly picked members, so later finds walk chains of growing depth
  task automatic build_block(input int k);
    int members [$];
    int size;
    int span;
    int i;
    int j;
    int t;
    int x;
    int y;
    size = 1 << k;
    for (i = 0; i < size; i++) members.push_back(next_fresh + i);
    next_fresh += size;
    for (i = size - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = members[i];
      members[i] = members[j];
      members[j] = t;
    end
    for (span = 1; span < size; span *= 2) begin
      for (i = 0; i < size; i += 2 * span) begin
        x = members[i + $urandom_range(0, span - 1)];
        y = members[i + span + $urandom_range(0, span - 1)];
        if ($urandom_range(0, 1)) push_word(ACT_UNION, x, y);
        else push_word(ACT_UNION, y, x);
      end
      if ($urandom_range(0, 1))
        push_word(ACT_FIND, members[$urandom_range(0, size - 1)], $urandom_range(0, 255));
    end
    push_word(ACT_FIND, members[$urandom_range(0, size - 1)], $urandom_range(0, 255));
    push_word(ACT_CONN, members[$urandom_range(0, size - 1)],
              members[$urandom_range(0, size - 1)]);
  endtask

  task automatic random_phase(input int n);
    int      start;
    int      r;
    int      k;
    int      a;
    int      b;
    action_t act;
    start = words_queued;
    while (words_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 15 && next_fresh + 4 <= stim_lim) begin
        k = 2;
        while (k < 5 && next_fresh + (2 << k) <= stim_lim && $urandom_range(0, 1)) k++;
        build_block(k);
      end else if (r < 75 && stim_lim > 0) begin
        r = $urandom_range(0, 99);
        act = (r < 45) ? ACT_FIND : (r < 88) ? ACT_CONN : ACT_UNION;
        push_word(act, $urandom_range(0, stim_lim - 1), $urandom_range(0, stim_lim - 1));
      end else if (r < 88 && stim_lim < MAX_NODES) begin
        a   = $urandom_range(stim_lim, MAX_NODES - 1);
        b   = $urandom_range(0, MAX_NODES - 1);
        act = action_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) push_word(act, a, b);
        else push_word(act, b, a);
      end else begin
        push_word(action_t'($urandom_range(0, 3)), $urandom_range(0, MAX_NODES - 1),
                  $urandom_range(0, MAX_NODES - 1));
      end
    end
  endtask

  initial begin
    logic [APB_DW-1:0] plan [8];
    plan = '{32'd64, 32'd128, 32'd20, 32'd256, 32'hFFFF_FEC8, 32'd511, 32'd3, 32'd256};
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_FIND;
    in_ch.node_a  = '0;
    in_ch.node_b  = '0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      parent_tbl[i] = i[NODE_W-1:0];
      rank_tbl[i]   = '0;
    end
    node_count   = NUM_NODES_RST;
    stim_lim     = MAX_NODES;
    faults       = 0;
    words_queued = 0;
    next_fresh   = 4;
    idle_cycles  = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full node range: both ends, equal and unequal ranks, compression, no-op code
    push_word(ACT_FIND, 0, 0);
    push_word(ACT_FIND, 255, 255);
    push_word(ACT_UNION, 0, 255);
    push_word(ACT_CONN, 255, 0);
    push_word(ACT_UNION, 1, 2);
    push_word(ACT_UNION, 2, 255);
    push_word(ACT_FIND, 255, 0);
    push_word(ACT_UNION, 255, 255);
    push_word(ACT_CONN, 0, 3);
    push_word(ACT_NONE, 255, 255);
    push_word(ACT_UNION, 3, 1);
    push_word(ACT_FIND, 3, 0);

    // zero node count flags every find, union and connected word
    set_node_count(0);
    push_word(ACT_FIND, 0, 0);
    push_word(ACT_UNION, 0, 0);
    push_word(ACT_CONN, 255, 0);
    push_word(ACT_NONE, 0, 255);

    // single node: index 1 is out of range on either side
    set_node_count(1);
    push_word(ACT_FIND, 0, 255);
    push_word(ACT_FIND, 1, 0);
    push_word(ACT_UNION, 0, 0);
    push_word(ACT_CONN, 0, 1);
    push_word(ACT_CONN, 1, 0);
    push_word(ACT_UNION, 1, 1);

    // oversized count saturates; tables untouched by the writes
    set_node_count(511);
    push_word(ACT_FIND, 255, 0);
    push_word(ACT_CONN, 255, 254);
    push_word(ACT_UNION, 254, 0);

    set_node_count(2);
    push_word(ACT_UNION, 1, 0);
    push_word(ACT_FIND, 2, 1);

    foreach (plan[p]) begin
      set_node_count(plan[p]);
      random_phase(PHASE_WORDS / 2);
      if (p == 0 || $urandom_range(0, 1)) settle();
      random_phase(PHASE_WORDS - PHASE_WORDS / 2);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dsu_pkg.sv
src/dsu_if.sv
src/dsu_ram.sv
src/dsu_find.sv
src/disjoint_set_union_find.sv
tb/disjoint_set_union_find_tb.sv
